### hdl/tpr_pkg.sv
// Shared types, constants and helper functions of the turning point reducer.
package tpr_pkg;

   // Buffer length limit; the point with index MAX_POINTS-1 closes a buffer.
   localparam int MAX_POINTS = 65536;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int AMP_W      = 8;
   localparam int DUR_W      = 24;
   localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

   // Depth of the result queue; a power of two so the pointers wrap.
   localparam int OUT_DEPTH  = 8;

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [1:0] {
      CSR_AMP_THRESHOLD  = 2'd0,
      CSR_SPAN_THRESHOLD = 2'd1,
      CSR_MERGE_LIMIT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  point_amplitude;
      logic [15:0] point_duration;
      logic        last_point;
   } req_type;

   typedef struct packed {
      logic [7:0]  turn_amplitude;
      logic [23:0] turn_duration;
      logic [15:0] source_index;
      logic        final_result;
   } rsp_type;

   typedef struct packed {
      logic [AMP_W-1:0] amp;
      logic [DUR_W-1:0] dur;
      idx_type          idx;
   } tpoint_type;

   // Pass-two state: closed point count (saturates at two) and the held pair.
   typedef struct packed {
      logic [1:0] count;
      tpoint_type prev;
      tpoint_type cur;
   } close_ctx_type;

   typedef struct packed {
      close_ctx_type ctx;
      logic          emit;
      tpoint_type    pt;
   } close_res_type;

   function automatic logic [DUR_W-1:0] sat_add(input logic [DUR_W-1:0] a,
                                                input logic [DUR_W-1:0] b);
      logic [DUR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DUR_W] ? DUR_MAX : s[DUR_W-1:0];
   endfunction

   function automatic logic [AMP_W-1:0] abs_diff(input logic [AMP_W-1:0] a,
                                                 input logic [AMP_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // Merge test gap^2 + dur^2 < limit. A duration of 4096 or more squares to at
   // least 2^24, which no 24-bit limit exceeds, so only the low 12 bits are
   // multiplied.
   function automatic logic merge_small(input logic [AMP_W-1:0] gap,
                                        input logic [DUR_W-1:0] dur,
                                        input logic [DUR_W-1:0] limit);
      logic [15:0] g2;
      logic [23:0] d2;
      logic [24:0] sq;
      g2 = 16'(gap) * 16'(gap);
      d2 = 24'(dur[11:0]) * 24'(dur[11:0]);
      sq = 25'(g2) + 25'(d2);
      return (dur[DUR_W-1:12] == '0) && (sq < {1'b0, limit});
   endfunction

   // Folds one closed point into the pass-two state. The merge test result is
   // computed outside so the two multiplies of a step run side by side.
   function automatic close_res_type close_point(input close_ctx_type ctx,
                                                 input tpoint_type    p,
                                                 input logic          fold_ok);
      close_res_type r;
      logic          mono;
      r      = '0;
      r.ctx  = ctx;
      r.emit = 1'b0;
      r.pt   = ctx.cur;
      mono   = ((ctx.prev.amp < ctx.cur.amp) && (ctx.cur.amp < p.amp)) ||
               ((ctx.prev.amp > ctx.cur.amp) && (ctx.cur.amp > p.amp));
      case (ctx.count)
         2'd0: begin
            r.emit      = 1'b1;
            r.pt        = p;
            r.ctx.prev  = p;
            r.ctx.count = 2'd1;
         end
         2'd1: begin
            r.ctx.cur   = p;
            r.ctx.count = 2'd2;
         end
         default: begin
            if (mono || fold_ok) begin
               r.ctx.cur.dur = sat_add(ctx.cur.dur, p.dur);
               r.ctx.cur.amp = p.amp;
               r.ctx.cur.idx = p.idx;
            end else begin
               r.emit     = 1'b1;
               r.pt       = ctx.cur;
               r.ctx.prev = ctx.cur;
               r.ctx.cur  = p;
            end
         end
      endcase
      return r;
   endfunction

   function automatic rsp_type to_rsp(input tpoint_type p, input logic fin);
      rsp_type r;
      r.turn_amplitude = p.amp;
      r.turn_duration  = p.dur;
      r.source_index   = 16'(p.idx);
      r.final_result   = fin;
      return r;
   endfunction

endpackage

### hdl/turning_point_reducer_top.sv
// Turning point reducer: input register, combinational reduction, result queue.
// The results of an input item enter the result queue when its input register stage advances.
// Throughput: one input item per cycle while the result queue has room for three more
// results, as one item can add up to three; the output drains one per cycle on rsp_ready.
// Reset (synchronous, active high) restores the register defaults, clears all tracking
// state, the input register and the result queue.
module turning_point_reducer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tpr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tpr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_wdata
);
   import tpr_pkg::*;

   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   // Configuration registers.
   logic [7:0]       amp_threshold_ff;
   logic [15:0]      span_threshold_ff;
   logic [DUR_W-1:0] merge_limit_ff;

   // Input register.
   logic    stage_valid_ff;
   req_type stage_data_ff;
   logic    stage_fire;

   // Pass-one tracking state and its next values.
   idx_type          point_counter_ff, point_counter_in;
   idx_type          min_index_ff, min_index_in;
   idx_type          max_index_ff, max_index_in;
   logic [AMP_W-1:0] min_amplitude_ff, min_amplitude_in;
   logic [AMP_W-1:0] max_amplitude_ff, max_amplitude_in;
   logic [DUR_W-1:0] time_at_min_ff, time_at_min_in;
   logic [DUR_W-1:0] time_at_max_ff, time_at_max_in;
   logic [DUR_W-1:0] running_time_ff, running_time_in;
   logic [DUR_W-1:0] since_min_ff, since_min_in;
   logic [DUR_W-1:0] since_max_ff, since_max_in;
   logic [DUR_W-1:0] span_between_ff, span_between_in;
   close_ctx_type    ctx_ff, ctx_in;

   // Result queue.
   rsp_type            queue_ff [OUT_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               pop;

   // Up to three results of the current step, in order.
   rsp_type          res1, res2, res3;
   logic             emit1, emit2, emit3;
   logic [PTR_W-1:0] pos2, pos3;
   logic [1:0]       push_n;

   // Configuration is always accepted; writes to an unused index are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_threshold_ff  <= 8'd6;
         span_threshold_ff <= 16'd12;
         merge_limit_ff    <= 24'd20;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_AMP_THRESHOLD:  amp_threshold_ff  <= csr_wdata[7:0];
            CSR_SPAN_THRESHOLD: span_threshold_ff <= csr_wdata[15:0];
            CSR_MERGE_LIMIT:    merge_limit_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The stage holding an item advances once the queue can take all the results
   // it might produce. The input register refills in the same cycle.
   assign stage_fire = stage_valid_ff && (count_ff <= CNT_W'(OUT_DEPTH - 3));
   assign req_ready  = !stage_valid_ff || stage_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         stage_data_ff <= req_data;
      end
   end

   // Reduction of one point. Pass one looks for a turn; on a turn the extremes
   // close in index order and pass two folds them into the held pair.
   always_comb begin
      logic [AMP_W-1:0] a;
      logic [DUR_W-1:0] m;
      logic             last;
      logic             first;
      logic [DUR_W-1:0] ln, lx, rt1, carry;
      logic [AMP_W-1:0] dan, dam;
      logic             turn, two_close;
      tpoint_type       c1, c2;
      logic             small1, small2;
      close_res_type    r1, r2;
      close_ctx_type    ctx_mid;

      a     = stage_data_ff.point_amplitude;
      m     = DUR_W'(stage_data_ff.point_duration);
      first = (point_counter_ff == '0);
      last  = stage_data_ff.last_point ||
              (point_counter_ff >= IDX_W'(MAX_POINTS - 1));

      point_counter_in = point_counter_ff;
      min_index_in     = min_index_ff;
      max_index_in     = max_index_ff;
      min_amplitude_in = min_amplitude_ff;
      max_amplitude_in = max_amplitude_ff;
      time_at_min_in   = time_at_min_ff;
      time_at_max_in   = time_at_max_ff;
      running_time_in  = running_time_ff;
      since_min_in     = since_min_ff;
      since_max_in     = since_max_ff;
      span_between_in  = span_between_ff;
      ctx_in           = ctx_ff;

      ln  = sat_add(since_min_ff, m);
      lx  = sat_add(since_max_ff, m);
      rt1 = sat_add(running_time_ff, m);
      dan = abs_diff(max_amplitude_ff, a);
      dam = abs_diff(min_amplitude_ff, a);
      turn = !first &&
             (((dan > amp_threshold_ff) && (ln > DUR_W'(span_threshold_ff))) ||
              ((lx > DUR_W'(span_threshold_ff)) && (dam > amp_threshold_ff)));

      // Points that close on a turn. With distinct extremes the earlier one
      // carries its own time and the later one the span between them; with a
      // single extreme only that one closes.
      two_close = (min_index_ff != max_index_ff);
      if (two_close && (min_index_ff < max_index_ff)) begin
         c1    = '{amp: min_amplitude_ff, dur: time_at_min_ff, idx: min_index_ff};
         c2    = '{amp: max_amplitude_ff, dur: span_between_ff, idx: max_index_ff};
         carry = since_max_ff;
      end else if (two_close) begin
         c1    = '{amp: max_amplitude_ff, dur: time_at_max_ff, idx: max_index_ff};
         c2    = '{amp: min_amplitude_ff, dur: span_between_ff, idx: min_index_ff};
         carry = since_min_ff;
      end else begin
         c1    = '{amp: max_amplitude_ff, dur: time_at_max_ff, idx: max_index_ff};
         c2    = c1;
         carry = '0;
      end

      // After the first close the held current amplitude is always c1's, so
      // both merge tests are formed in parallel from registered values.
      small1 = merge_small(abs_diff(ctx_ff.cur.amp, c1.amp), c1.dur, merge_limit_ff);
      small2 = merge_small(abs_diff(c1.amp, c2.amp), c2.dur, merge_limit_ff);

      r1      = close_point(ctx_ff, c1, small1);
      r2      = close_point(r1.ctx, c2, small2);
      ctx_mid = two_close ? r2.ctx : r1.ctx;

      emit1 = 1'b0;
      emit2 = 1'b0;

      if (first) begin
         // The first point of a buffer only seeds the extremes.
         min_index_in     = '0;
         max_index_in     = '0;
         min_amplitude_in = a;
         max_amplitude_in = a;
         time_at_min_in   = m;
         time_at_max_in   = m;
         running_time_in  = '0;
         since_min_in     = '0;
         since_max_in     = '0;
         span_between_in  = '0;
         ctx_in.count     = 2'd0;
      end else if (turn) begin
         emit1            = r1.emit;
         emit2            = two_close && r2.emit;
         ctx_in           = ctx_mid;
         min_index_in     = point_counter_ff;
         max_index_in     = point_counter_ff;
         min_amplitude_in = a;
         max_amplitude_in = a;
         running_time_in  = sat_add(carry, m);
         time_at_min_in   = sat_add(carry, m);
         time_at_max_in   = sat_add(carry, m);
         since_min_in     = '0;
         since_max_in     = '0;
         span_between_in  = '0;
      end else begin
         running_time_in = rt1;
         since_min_in    = ln;
         since_max_in    = lx;
         if (a > max_amplitude_ff) begin
            max_index_in     = point_counter_ff;
            max_amplitude_in = a;
            time_at_max_in   = rt1;
            since_max_in     = '0;
            span_between_in  = ln;
         end
         if (a < min_amplitude_ff) begin
            min_index_in     = point_counter_ff;
            min_amplitude_in = a;
            time_at_min_in   = rt1;
            since_min_in     = '0;
            span_between_in  = lx;
         end
      end

      // On the last point the held current point flushes if two or more
      // points closed; the open point after the last turn is dropped.
      emit3 = last && !first && (ctx_in.count == 2'd2);

      res1 = to_rsp(r1.pt, last && !emit2 && !emit3);
      res2 = to_rsp(r2.pt, last && !emit3);
      res3 = to_rsp(ctx_in.cur, last);

      point_counter_in = last ? '0 : (point_counter_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_counter_ff <= '0;
         min_index_ff     <= '0;
         max_index_ff     <= '0;
         min_amplitude_ff <= '0;
         max_amplitude_ff <= '0;
         time_at_min_ff   <= '0;
         time_at_max_ff   <= '0;
         running_time_ff  <= '0;
         since_min_ff     <= '0;
         since_max_ff     <= '0;
         span_between_ff  <= '0;
         ctx_ff           <= '0;
      end else if (stage_fire) begin
         point_counter_ff <= point_counter_in;
         min_index_ff     <= min_index_in;
         max_index_ff     <= max_index_in;
         min_amplitude_ff <= min_amplitude_in;
         max_amplitude_ff <= max_amplitude_in;
         time_at_min_ff   <= time_at_min_in;
         time_at_max_ff   <= time_at_max_in;
         running_time_ff  <= running_time_in;
         since_min_ff     <= since_min_in;
         since_max_ff     <= since_max_in;
         span_between_ff  <= span_between_in;
         ctx_ff           <= ctx_in;
      end
   end

   // Results are packed into consecutive queue slots in their causal order.
   assign pos2   = PTR_W'(emit1);
   assign pos3   = PTR_W'(emit1) + PTR_W'(emit2);
   assign push_n = stage_fire ? (2'(emit1) + 2'(emit2) + 2'(emit3)) : 2'd0;

   always_ff @(posedge clock) begin
      if (stage_fire) begin
         if (emit1) queue_ff[wr_ptr_ff] <= res1;
         if (emit2) queue_ff[wr_ptr_ff + pos2] <= res2;
         if (emit3) queue_ff[wr_ptr_ff + pos3] <= res3;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_n);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff  <= count_ff + CNT_W'(push_n) - CNT_W'(pop);
      end
   end

endmodule

### tb/sv/tpr_checker.sv
// Checker for the turning point reducer: watches all three channels and checks every result item.
`timescale 1ns / 1ps

module tpr_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  tpr_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  tpr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_wdata,
   output int               mismatches,
   output int               turns_pending,
   output int               turns_checked
);
   import tpr_pkg::*;

   localparam logic [7:0]  AMP_THR_DEFAULT   = 8'd6;
   localparam logic [15:0] SPAN_THR_DEFAULT  = 16'd12;
   localparam logic [23:0] MERGE_LIM_DEFAULT = 24'd20;
   localparam logic [15:0] LAST_INDEX        = 16'(MAX_POINTS - 1);

   typedef struct packed {
      logic [7:0]  amp;
      logic [23:0] dur;
      logic [15:0] idx;
   } turn_point_type;

   // Register copies.
   logic [7:0]  amp_thr;
   logic [15:0] span_thr;
   logic [23:0] merge_lim;

   // Pass one: running extremes since the last turn.
   logic [15:0] pt_count;
   logic [15:0] lo_idx, hi_idx;
   logic [7:0]  lo_amp, hi_amp;
   logic [23:0] lo_time, hi_time, run_time;
   logic [23:0] after_lo, after_hi, between;

   // Pass two: closed points and the held pair.
   logic [1:0]     closed_seen;
   turn_point_type held_prev, held_cur;

   rsp_type step_turns[$];
   rsp_type expected_turns[$];

   function automatic logic [23:0] dur_sum(input logic [23:0] a, input logic [23:0] b);
      logic [24:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[24] ? 24'hFFFFFF : s[23:0];
   endfunction

   function automatic logic [7:0] amp_gap(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   task automatic restore_defaults();
      amp_thr     = AMP_THR_DEFAULT;
      span_thr    = SPAN_THR_DEFAULT;
      merge_lim   = MERGE_LIM_DEFAULT;
      pt_count    = '0;
      lo_idx      = '0;
      hi_idx      = '0;
      lo_amp      = '0;
      hi_amp      = '0;
      lo_time     = '0;
      hi_time     = '0;
      run_time    = '0;
      after_lo    = '0;
      after_hi    = '0;
      between     = '0;
      closed_seen = '0;
      held_prev   = '0;
      held_cur    = '0;
   endtask

   task automatic emit_turn(input turn_point_type p);
      rsp_type r;
      r.turn_amplitude = p.amp;
      r.turn_duration  = p.dur;
      r.source_index   = p.idx;
      r.final_result   = 1'b0;
      step_turns.push_back(r);
   endtask

   // Pass two: a closed point either becomes held, folds into the held one, or
   // pushes the held one out as a result.
   task automatic fold_closed(input logic [7:0] amp, input logic [15:0] idx,
                              input logic [23:0] dur);
      turn_point_type p;
      logic [7:0]     gap;
      longint         sq;
      logic           mono;
      p.amp = amp;
      p.dur = dur;
      p.idx = idx;
      case (closed_seen)
         2'd0: begin
            emit_turn(p);
            held_prev   = p;
            closed_seen = 2'd1;
         end
         2'd1: begin
            held_cur    = p;
            closed_seen = 2'd2;
         end
         default: begin
            gap  = amp_gap(held_cur.amp, amp);
            sq   = longint'(gap) * longint'(gap) + longint'(dur) * longint'(dur);
            mono = (held_prev.amp < held_cur.amp && held_cur.amp < amp) ||
                   (held_prev.amp > held_cur.amp && held_cur.amp > amp);
            if (mono || sq < longint'(merge_lim)) begin
               held_cur.dur = dur_sum(held_cur.dur, dur);
               held_cur.amp = amp;
               held_cur.idx = idx;
            end else begin
               emit_turn(held_cur);
               held_prev = held_cur;
               held_cur  = p;
            end
         end
      endcase
   endtask

   task automatic predict_point(input req_type item);
      logic [7:0]  a, dan, dam;
      logic [23:0] m, ln, lx, carry;
      logic [15:0] i;
      logic        last;
      rsp_type     r;
      a    = item.point_amplitude;
      m    = {8'd0, item.point_duration};
      i    = pt_count;
      last = item.last_point || (pt_count == LAST_INDEX);
      step_turns.delete();
      if (i == 16'd0) begin
         lo_idx      = '0;
         hi_idx      = '0;
         lo_amp      = a;
         hi_amp      = a;
         lo_time     = m;
         hi_time     = m;
         run_time    = '0;
         after_lo    = '0;
         after_hi    = '0;
         between     = '0;
         closed_seen = '0;
      end else begin
         ln       = dur_sum(after_lo, m);
         lx       = dur_sum(after_hi, m);
         dan      = amp_gap(hi_amp, a);
         dam      = amp_gap(lo_amp, a);
         run_time = dur_sum(run_time, m);
         if ((dan > amp_thr && ln > span_thr) || (lx > span_thr && dam > amp_thr)) begin
            // Close the extremes in index order; equal indices close one point.
            if (lo_idx != hi_idx) begin
               if (lo_idx < hi_idx) begin
                  fold_closed(lo_amp, lo_idx, lo_time);
                  fold_closed(hi_amp, hi_idx, between);
                  carry = after_hi;
               end else begin
                  fold_closed(hi_amp, hi_idx, hi_time);
                  fold_closed(lo_amp, lo_idx, between);
                  carry = after_lo;
               end
            end else begin
               fold_closed(hi_amp, hi_idx, hi_time);
               carry = '0;
            end
            lo_idx   = i;
            hi_idx   = i;
            lo_amp   = a;
            hi_amp   = a;
            run_time = dur_sum(carry, m);
            lo_time  = run_time;
            hi_time  = run_time;
            after_lo = '0;
            after_hi = '0;
            between  = '0;
         end else begin
            after_lo = ln;
            after_hi = lx;
            if (a > hi_amp) begin
               hi_idx   = i;
               hi_amp   = a;
               hi_time  = run_time;
               after_hi = '0;
               between  = ln;
            end
            if (a < lo_amp) begin
               lo_idx   = i;
               lo_amp   = a;
               lo_time  = run_time;
               after_lo = '0;
               between  = lx;
            end
         end
      end
      if (last) begin
         if (i != 16'd0 && closed_seen >= 2'd2) emit_turn(held_cur);
         pt_count = '0;
      end else begin
         pt_count = i + 16'd1;
      end
      foreach (step_turns[k]) begin
         r              = step_turns[k];
         r.final_result = last && (k == step_turns.size() - 1);
         expected_turns.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input logic [23:0] want,
                              input logic [23:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   initial begin
      mismatches    = 0;
      turns_pending = 0;
      turns_checked = 0;
      restore_defaults();
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         restore_defaults();
         expected_turns.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_AMP_THRESHOLD:  amp_thr   = csr_wdata[7:0];
               CSR_SPAN_THRESHOLD: span_thr  = csr_wdata[15:0];
               CSR_MERGE_LIMIT:    merge_lim = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_point(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_turns.size() == 0) begin
               $error("result item with none expected: amplitude %0d, index %0d",
                      rsp_data.turn_amplitude, rsp_data.source_index);
               mismatches++;
            end else begin
               want = expected_turns.pop_front();
               check_field("turn_amplitude", 24'(want.turn_amplitude),
                           24'(rsp_data.turn_amplitude));
               check_field("turn_duration", want.turn_duration, rsp_data.turn_duration);
               check_field("source_index", 24'(want.source_index),
                           24'(rsp_data.source_index));
               check_field("final_result", 24'(want.final_result),
                           24'(rsp_data.final_result));
            end
            turns_checked++;
         end
      end
      turns_pending = expected_turns.size();
   end

endmodule

### tb/sv/tb.sv
// Testbench top for the turning point reducer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
   import tpr_pkg::*;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = '0;
   logic [23:0]   csr_wdata = '0;

   int mismatches;
   int turns_pending;
   int turns_checked;

   // Percent chance per cycle that the sender idles or the receiver stalls.
   int idle_pct  = 0;
   int stall_pct = 0;

   int items_sent    = 0;
   int buffers_sent  = 0;
   int walk_amp      = 128;
   bit stuck         = 1'b0;

   turning_point_reducer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tpr_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .turns_pending (turns_pending),
      .turns_checked (turns_checked)
   );

   // The clock runs with a 12 ns period, low for the first half.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The receiver decides once per cycle, at the falling edge, whether it stalls.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Sends one point and returns at the falling edge after it was accepted. The
   // valid line is left high, so back-to-back items keep it up without a glitch;
   // each falling edge sees at most one assignment to it.
   task automatic send_point(input logic [7:0] amp, input logic [15:0] dur,
                             input logic last);
      req_type item;
      item.point_amplitude = amp;
      item.point_duration  = dur;
      item.last_point      = last;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      if (last) buffers_sent++;
   endtask

   // Registers are only written with the block idle: the sender is stopped, every
   // expected result has arrived, and a further wait lets any point that closed
   // nothing finish inside the block.
   task automatic apply_config(input logic [7:0] amp_thr, input logic [15:0] span_thr,
                               input logic [23:0] merge_lim);
      csr_index_type idx [3];
      logic [23:0]   val [3];
      idx[0] = CSR_AMP_THRESHOLD;
      idx[1] = CSR_SPAN_THRESHOLD;
      idx[2] = CSR_MERGE_LIMIT;
      val[0] = {16'd0, amp_thr};
      val[1] = {8'd0, span_thr};
      val[2] = merge_lim;
      req_valid <= 1'b0;
      while (turns_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // One well-formed buffer with random content: a random walk in amplitude with
   // jumps to both rails, mostly short durations and now and then a full-range one.
   task automatic send_random_buffer();
      int          len;
      logic [15:0] dur;
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 30);
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(9))
            0:       walk_amp = 0;
            1:       walk_amp = 255;
            default: walk_amp = walk_amp + $urandom_range(0, 80) - 40;
         endcase
         if (walk_amp < 0) walk_amp = 0;
         if (walk_amp > 255) walk_amp = 255;
         case ($urandom_range(9))
            0:       dur = 16'd0;
            1:       dur = 16'($urandom_range(65535));
            default: dur = 16'($urandom_range(1, 40));
         endcase
         send_point(8'(walk_amp), dur, k == len - 1);
      end
   endtask

   initial begin
      int drain_cycles;
      int phase_start;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed points under the reset values of the registers. A buffer of a
      // single point writes nothing.
      send_point(8'd128, 16'd5, 1'b1);
      // Both amplitude rails, zero and full durations. The first turn finds
      // both extremes still on the first point, so only one point closes.
      send_point(8'd100, 16'd0, 1'b0);
      send_point(8'd200, 16'd65535, 1'b0);
      send_point(8'd0, 16'd20, 1'b0);
      send_point(8'd255, 16'd20, 1'b0);
      send_point(8'd0, 16'd20, 1'b0);
      send_point(8'd255, 16'd65535, 1'b0);
      send_point(8'd128, 16'd1, 1'b0);
      send_point(8'd129, 16'd1, 1'b1);
      // A rising run, so held points fold in as a monotone sequence, then a
      // reversal and a flush of the held point.
      send_point(8'd10, 16'd1, 1'b0);
      send_point(8'd10, 16'd1, 1'b0);
      send_point(8'd40, 16'd13, 1'b0);
      send_point(8'd70, 16'd13, 1'b0);
      send_point(8'd100, 16'd13, 1'b0);
      send_point(8'd130, 16'd13, 1'b0);
      send_point(8'd160, 16'd13, 1'b0);
      send_point(8'd20, 16'd13, 1'b0);
      send_point(8'd200, 16'd13, 1'b1);
      // A buffer without a turn: its last step writes nothing and marks nothing.
      send_point(8'd128, 16'd3, 1'b0);
      send_point(8'd130, 16'd3, 1'b1);

      // Duration saturation: a long flat stretch at full duration drives every
      // running sum to its ceiling; a small dip then becomes a minimum whose
      // closing duration is saturated, and the swings after it close turns.
      apply_config(8'd10, 16'd65535, 24'd0);
      for (int k = 0; k < 258; k++) send_point(8'd128, 16'd65535, 1'b0);
      send_point(8'd125, 16'd65535, 1'b0);
      for (int k = 0; k < 10; k++) begin
         send_point(8'($urandom_range(255)), 16'd65535, k == 9);
      end

      // Random phases: every idling mode under two register settings each,
      // with the register extremes among them.
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: apply_config(8'd0, 16'd0, 24'd0);
            1: apply_config(8'd6, 16'd12, 24'd20);
            2: apply_config(8'd255, 16'd65535, 24'hFFFFFF);
            4: apply_config(8'd3, 16'd5, 24'hFFFFFF);
            6: apply_config(8'd0, 16'd0, 24'd0);
            default: apply_config(8'($urandom_range(2, 40)), 16'($urandom_range(0, 60)),
                                  24'($urandom_range(0, 5000)));
         endcase
         case (p / 2)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 81; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 81; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < 12) send_random_buffer();
      end

      // Let everything drain, then keep watching for stray results.
      req_valid <= 1'b0;
      drain_cycles = 0;
      while (turns_pending != 0 && drain_cycles < 20000) begin
         @(negedge clock);
         drain_cycles++;
      end
      if (turns_pending != 0) stuck = 1'b1;
      repeat (20) @(negedge clock);

      $display("Sent %0d points in %0d buffers and checked %0d turning points.",
               items_sent, buffers_sent, turns_checked);
      $display("Covered duration saturation and four idling modes over eight settings.");
      if (!stuck && mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Hard stop, well beyond the slowest legal run.
   initial begin
      #12_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
